// File: sv/psfp_pkg.sv
// Shared types and constants for the four-policy process scheduler.
package psfp_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int SLOT_W    = $clog2(MAX_JOBS);
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int TIME_BITS = 16;
    localparam int BURST_W   = 8;
    localparam int OUT_W     = 16;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Item commands.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ARRIVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Policy register codes.
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_SRT  = 2'd2;
    localparam logic [1:0] POL_RR   = 2'd3;

    // Scan keys.
    localparam logic [1:0] KEY_ARRIVAL = 2'd0;
    localparam logic [1:0] KEY_BURST   = 2'd1;
    localparam logic [1:0] KEY_REMAIN  = 2'd2;

    // Register byte addresses.
    localparam logic [2:0] ADDR_POLICY  = 3'd0;
    localparam logic [2:0] ADDR_QUANTUM = 3'd4;

    // One job table entry.
    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [BURST_W-1:0]   burst;
        logic [BURST_W-1:0]   remaining;
    } job_entry_t;

endpackage

// File: sv/process_scheduler_four_policies.sv
// Top level of the four-policy process scheduler.
//
// Usage: the s_ channel takes one item per handshake: tuser carries the
// command (tick, arrive, clear) and tdata the burst of an arriving job.
// Each item yields exactly one result item on the m_ channel.
// Policy and quantum are written through the APB port; the user writes them
// only while idle, which the block itself does not enforce. Arrive, clear
// and unknown commands go straight to the done state. A tick that keeps the
// running job reads its entry and executes it; a tick that has to pick a new
// job scans the 16-entry job memory one slot per cycle; round robin instead
// pops the ready queue entry by entry. These memory accesses set the pace:
// one item is worked on at a time.
// The result sits in an output register; the next item is taken while it
// waits, and its own result waits in a done state until the receiver
// takes the previous one, so a stalled receiver holds the block.
// Reset clears the scheduling state, the queue pointers and the clock and
// sets policy to first come first served and quantum to 1. The job and
// queue memories are not cleared; they are only read for live entries.
module process_scheduler_four_policies
    import psfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] burst
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] slot_index, [19:4] turnaround,
                                   // [35:20] waiting, [51:36] clock_now, rest 0
    output logic [2:0]  m_tuser    // [0] idle, [1] full_res, [2] finished
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_POP, ST_POPW, ST_SCAN, ST_READ, ST_EXEC, ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [1:0] policy_reg;
    logic [7:0] quantum_reg;

    // Scheduler state.
    logic [MAX_JOBS-1:0]  pending_reg;
    logic [CNT_W-1:0]     job_count_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [SLOT_W-1:0]    running_slot_reg;
    logic                 running_valid_reg;
    logic [7:0]           slice_reg;
    logic [SLOT_W-1:0]    head_reg;
    logic [SLOT_W-1:0]    tail_reg;
    logic [CNT_W-1:0]     fcount_reg;
    logic [SLOT_W-1:0]    requeue_slot_reg;
    logic                 requeue_valid_reg;

    // Per-item working registers.
    logic [SLOT_W-1:0]    run_slot_reg;
    logic [1:0]           key_reg;
    logic [CNT_W-1:0]     scan_idx_reg;
    logic                 scan_chk_reg;
    logic [SLOT_W-1:0]    scan_slot_reg;
    logic                 have_reg;
    logic [SLOT_W-1:0]    best_slot_reg;
    logic [TIME_BITS-1:0] best_val_reg;

    // Result being built.
    logic [SLOT_W-1:0]    res_slot_reg;
    logic                 res_idle_reg;
    logic                 res_full_reg;
    logic                 res_fin_reg;
    logic [OUT_W-1:0]     res_ta_reg;
    logic [OUT_W-1:0]     res_wait_reg;
    logic [OUT_W-1:0]     res_clk_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    // Memories.
    job_entry_t        job_mem [MAX_JOBS];
    logic [SLOT_W-1:0] fifo_mem [MAX_JOBS];
    job_entry_t        job_rd_reg;
    logic [SLOT_W-1:0] fifo_rd_reg;

    logic              job_we;
    logic [SLOT_W-1:0] job_waddr;
    job_entry_t        job_wdata;
    logic [SLOT_W-1:0] job_raddr;
    logic              fifo_we;
    logic [SLOT_W-1:0] fifo_wdata;

    logic                 acc;
    logic                 table_full;
    logic                 fifo_full;
    logic [BURST_W-1:0]   burst_in;
    logic [7:0]           quantum_eff;
    logic [BURST_W-1:0]   rem_new;
    logic [7:0]           slice_dec;
    logic [TIME_BITS:0]   finish;
    logic [TIME_BITS-1:0] ta;
    logic [TIME_BITS-1:0] wt;
    logic [TIME_BITS-1:0] scan_val;
    logic [TIME_BITS-1:0] tick_inc;
    logic                 cfg_wr;

    assign s_tready   = (state_reg == ST_IDLE);
    assign acc        = s_tvalid && s_tready;
    assign table_full = (job_count_reg >= CNT_W'(MAX_JOBS));
    assign fifo_full  = (fcount_reg >= CNT_W'(MAX_JOBS));
    assign burst_in   = (s_tdata == '0) ? BURST_W'(1) : s_tdata;
    assign quantum_eff = (quantum_reg == '0) ? 8'd1 : quantum_reg;
    assign tick_inc   = (tick_reg == TIME_MAX) ? TIME_MAX : tick_reg + 1'b1;

    // Execute-step arithmetic on the entry just read.
    assign rem_new   = job_rd_reg.remaining - 1'b1;
    assign slice_dec = (policy_reg == POL_RR && slice_reg != '0) ? slice_reg - 1'b1 : slice_reg;
    assign finish    = {1'b0, tick_inc};
    assign ta = (finish >= {1'b0, job_rd_reg.arrival})
              ? TIME_BITS'(finish - {1'b0, job_rd_reg.arrival}) : '0;
    assign wt = (ta >= TIME_BITS'(job_rd_reg.burst))
              ? ta - TIME_BITS'(job_rd_reg.burst) : '0;

    // Key of the scanned entry.
    always_comb begin
        case (key_reg)
            KEY_ARRIVAL: scan_val = job_rd_reg.arrival;
            KEY_BURST:   scan_val = TIME_BITS'(job_rd_reg.burst);
            default:     scan_val = TIME_BITS'(job_rd_reg.remaining);
        endcase
    end

    // Memory port control.
    always_comb begin
        job_we    = 1'b0;
        job_waddr = job_count_reg[SLOT_W-1:0];
        job_wdata = '{arrival: tick_reg, burst: burst_in, remaining: burst_in};
        if (state_reg == ST_EXEC) begin
            job_we    = 1'b1;
            job_waddr = run_slot_reg;
            job_wdata = '{arrival: job_rd_reg.arrival, burst: job_rd_reg.burst,
                          remaining: rem_new};
        end else if (acc && s_tuser == CMD_ARRIVE && !table_full) begin
            job_we = 1'b1;
        end
        job_raddr = (state_reg == ST_SCAN) ? scan_idx_reg[SLOT_W-1:0] : run_slot_reg;
        fifo_we    = acc && !fifo_full &&
                     ((s_tuser == CMD_ARRIVE && !table_full) ||
                      (s_tuser == CMD_TICK && requeue_valid_reg));
        fifo_wdata = (s_tuser == CMD_ARRIVE) ? job_count_reg[SLOT_W-1:0] : requeue_slot_reg;
    end

    // Job table memory.
    always_ff @(posedge aclk) begin
        if (job_we) begin
            job_mem[job_waddr] <= job_wdata;
        end
        job_rd_reg <= job_mem[job_raddr];
    end

    // Ready queue memory.
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[tail_reg] <= fifo_wdata;
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr)
            ADDR_POLICY:  prdata = {30'd0, policy_reg};
            ADDR_QUANTUM: prdata = {24'd0, quantum_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= POL_FCFS;
            quantum_reg <= 8'd1;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_POLICY:  policy_reg  <= pwdata[1:0];
                ADDR_QUANTUM: quantum_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer: one item at a time through the memories.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pending_reg       <= '0;
            job_count_reg     <= '0;
            tick_reg          <= '0;
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            slice_reg         <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            fcount_reg        <= '0;
            requeue_slot_reg  <= '0;
            requeue_valid_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fifo_we) begin
                tail_reg   <= tail_reg + 1'b1;
                fcount_reg <= fcount_reg + 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        res_fin_reg  <= 1'b0;
                        res_ta_reg   <= '0;
                        res_wait_reg <= '0;
                        res_clk_reg  <= OUT_W'(tick_reg);
                        case (s_tuser)
                            CMD_ARRIVE: begin
                                res_idle_reg <= 1'b0;
                                res_full_reg <= table_full;
                                state_reg    <= ST_DONE;
                                if (table_full) begin
                                    res_slot_reg <= '0;
                                end else begin
                                    pending_reg[job_count_reg[SLOT_W-1:0]] <= 1'b1;
                                    job_count_reg <= job_count_reg + 1'b1;
                                    res_slot_reg  <= job_count_reg[SLOT_W-1:0];
                                end
                            end
                            CMD_CLEAR: begin
                                res_slot_reg      <= '0;
                                res_idle_reg      <= 1'b0;
                                res_full_reg      <= 1'b0;
                                state_reg         <= ST_DONE;
                                pending_reg       <= '0;
                                job_count_reg     <= '0;
                                tick_reg          <= '0;
                                running_slot_reg  <= '0;
                                running_valid_reg <= 1'b0;
                                slice_reg         <= '0;
                                head_reg          <= '0;
                                tail_reg          <= '0;
                                fcount_reg        <= '0;
                                requeue_slot_reg  <= '0;
                                requeue_valid_reg <= 1'b0;
                            end
                            CMD_TICK: begin
                                res_slot_reg      <= '0;
                                res_full_reg      <= 1'b0;
                                res_idle_reg      <= (pending_reg == '0);
                                requeue_valid_reg <= 1'b0;
                                scan_idx_reg <= '0;
                                scan_chk_reg <= 1'b0;
                                have_reg     <= 1'b0;
                                if (pending_reg == '0) begin
                                    running_valid_reg <= 1'b0;
                                    tick_reg          <= tick_inc;
                                    state_reg         <= ST_DONE;
                                end else begin
                                    case (policy_reg)
                                        POL_FCFS, POL_SJF: begin
                                            slice_reg <= '0;
                                            key_reg   <= policy_reg;
                                            if (running_valid_reg &&
                                                pending_reg[running_slot_reg]) begin
                                                run_slot_reg <= running_slot_reg;
                                                state_reg    <= ST_READ;
                                            end else begin
                                                state_reg <= ST_SCAN;
                                            end
                                        end
                                        POL_SRT: begin
                                            slice_reg <= '0;
                                            key_reg   <= KEY_REMAIN;
                                            state_reg <= ST_SCAN;
                                        end
                                        default: begin
                                            key_reg <= KEY_REMAIN;
                                            if (running_valid_reg && slice_reg != '0 &&
                                                pending_reg[running_slot_reg]) begin
                                                run_slot_reg <= running_slot_reg;
                                                state_reg    <= ST_READ;
                                            end else begin
                                                slice_reg <= quantum_eff;
                                                state_reg <= ST_POP;
                                            end
                                        end
                                    endcase
                                end
                            end
                            default: begin
                                res_slot_reg <= '0;
                                res_idle_reg <= 1'b0;
                                res_full_reg <= 1'b0;
                                state_reg    <= ST_DONE;
                            end
                        endcase
                    end
                end
                // Pop the queue head; stale entries are dropped.
                ST_POP: begin
                    if (fcount_reg == '0) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        head_reg   <= head_reg + 1'b1;
                        fcount_reg <= fcount_reg - 1'b1;
                        state_reg  <= ST_POPW;
                    end
                end
                ST_POPW: begin
                    if (pending_reg[fifo_rd_reg]) begin
                        run_slot_reg <= fifo_rd_reg;
                        state_reg    <= ST_READ;
                    end else begin
                        state_reg <= ST_POP;
                    end
                end
                // Minimum search, one slot per cycle, ties to the lower slot.
                ST_SCAN: begin
                    if (scan_chk_reg && pending_reg[scan_slot_reg] &&
                        (!have_reg || scan_val < best_val_reg)) begin
                        have_reg      <= 1'b1;
                        best_slot_reg <= scan_slot_reg;
                        best_val_reg  <= scan_val;
                    end
                    if (scan_idx_reg < CNT_W'(MAX_JOBS)) begin
                        scan_chk_reg  <= 1'b1;
                        scan_slot_reg <= scan_idx_reg[SLOT_W-1:0];
                        scan_idx_reg  <= scan_idx_reg + 1'b1;
                    end else begin
                        scan_chk_reg <= 1'b0;
                        if (!scan_chk_reg) begin
                            run_slot_reg <= best_slot_reg;
                            state_reg    <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EXEC;
                end
                // Run the chosen job for one tick and write it back.
                ST_EXEC: begin
                    res_slot_reg     <= run_slot_reg;
                    running_slot_reg <= run_slot_reg;
                    tick_reg         <= tick_inc;
                    if (rem_new == '0) begin
                        res_fin_reg       <= 1'b1;
                        res_ta_reg        <= OUT_W'(ta);
                        res_wait_reg      <= OUT_W'(wt);
                        pending_reg[run_slot_reg] <= 1'b0;
                        running_valid_reg <= 1'b0;
                        slice_reg         <= '0;
                    end else if (policy_reg == POL_RR && slice_dec == '0) begin
                        running_valid_reg <= 1'b0;
                        slice_reg         <= slice_dec;
                        requeue_slot_reg  <= run_slot_reg;
                        requeue_valid_reg <= 1'b1;
                    end else begin
                        running_valid_reg <= 1'b1;
                        slice_reg         <= slice_dec;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, res_clk_reg, res_wait_reg, res_ta_reg,
                                         res_slot_reg};
                        m_tuser_reg  <= {res_fin_reg, res_full_reg, res_idle_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: sv/psfp_checker.sv
// Port-level checker for the process scheduler, bound to the top level.
module psfp_sva
    import psfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A result held back by the receiver keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A completing tick never reports an idle tick or a refused arrive.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1])
        else $error("finished result carries other flags");

    // A refused arrive reports slot zero and no statistics.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[3:0] == '0 && m_tdata[35:4] == '0)
        else $error("refused arrive carries data");

    // An accepted item is not followed by another in the next cycle.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("two items taken back to back");

endmodule

bind process_scheduler_four_policies psfp_sva u_psfp_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
